FILE: rtl/vn_pkg.sv
package vn_pkg;

    localparam int IN_WIDTH_DEF      = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int OUT_W             = 16;
    localparam int THR_W             = 16;
    localparam int CFG_IDX_W         = 1;
    localparam int LANES             = 4;

    localparam logic [CFG_IDX_W-1:0] REG_SMALL_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOUR_COMPONENTS = 1'd1;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1;

endpackage

FILE: rtl/vector_normalize.sv
// channel   | handshake              | beat
// ----------+------------------------+-------------------------------------
// input     | in_valid / in_ready    | in_x, in_y, in_z, in_w
// output    | out_valid / out_ready  | out_x, out_y, out_z, out_w, too_small
// config    | cfg_we                 | cfg_index, cfg_data
//
// one beat per cycle unless the output stalls; the pipeline holds input registers,
// one root-bit cell per magnitude bit and one quotient-bit cell per result bit
// reset clears all valid flags, threshold to 1 and three-component mode
// the whole chain advances together; a stalled output beat holds every stage
module vector_normalize #(
    parameter int IN_WIDTH      = vn_pkg::IN_WIDTH_DEF,
    parameter int OUT_FRAC_BITS = vn_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [vn_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vn_pkg::THR_W-1:0]     cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [IN_WIDTH-1:0]   in_x,
    input  logic signed [IN_WIDTH-1:0]   in_y,
    input  logic signed [IN_WIDTH-1:0]   in_z,
    input  logic signed [IN_WIDTH-1:0]   in_w,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [vn_pkg::OUT_W-1:0] out_x,
    output logic signed [vn_pkg::OUT_W-1:0] out_y,
    output logic signed [vn_pkg::OUT_W-1:0] out_z,
    output logic signed [vn_pkg::OUT_W-1:0] out_w,
    output logic                         too_small
);
    import vn_pkg::*;

    localparam int W  = IN_WIDTH;
    localparam int MW = W + 1;
    localparam int RW = 2 * MW;
    localparam int QW = OUT_FRAC_BITS + 1;

    logic [THR_W-1:0] thr_reg;
    logic             four_reg;
    logic             en;

    logic [LANES-1:0][W-1:0]   in_vec;
    logic [LANES-1:0][W-1:0]   abs_next;
    logic [LANES-1:0]          neg_next;

    logic                      v0_reg, v1_reg, v2_reg, vt_reg, out_valid_reg;
    logic [LANES-1:0][W-1:0]   abs0_reg, abs1_reg, abs2_reg;
    logic [LANES-1:0]          neg0_reg, neg1_reg, neg2_reg, negt_reg;
    logic [LANES-1:0][2*W-1:0] sq1_reg;
    logic [64:0]               sum_full;
    logic [63:0]               sum_sat;
    logic [RW-1:0]             val2_reg;

    logic                          sv   [MW+1];
    logic [RW-1:0]                 sval [MW+1];
    logic [MW+1:0]                 srem [MW+1];
    logic [MW-1:0]                 sroot[MW+1];
    logic [LANES-1:0][W-1:0]       sabs [MW+1];
    logic [LANES-1:0]              sneg [MW+1];

    logic                          small_next;
    logic                          smallt_reg;
    logic [MW-1:0]                 magnt_reg;
    logic [LANES-1:0][MW:0]        remt_next;
    logic [LANES-1:0][MW:0]        remt_reg;

    logic                          dv    [QW+1];
    logic                          dsmall[QW+1];
    logic [MW-1:0]                 dmagn [QW+1];
    logic [LANES-1:0][MW:0]        drem  [QW+1];
    logic [LANES-1:0][QW-1:0]      dq    [QW+1];
    logic [LANES-1:0]              dneg  [QW+1];

    logic [LANES-1:0][OUT_W-1:0]   res_next, res_reg;
    logic                          small_out_reg;
    logic [63:0]                   qv;
    logic [63:0]                   rv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESHOLD_RESET;
            four_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SMALL_THRESHOLD: thr_reg  <= cfg_data;
                REG_FOUR_COMPONENTS: four_reg <= cfg_data[0];
                default:             thr_reg  <= thr_reg;
            endcase
        end
    end

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    assign in_vec = {in_w, in_z, in_y, in_x};

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            neg_next[i] = in_vec[i][W-1];
            abs_next[i] = in_vec[i][W-1] ? (~in_vec[i] + 1'b1) : in_vec[i];
        end
        if (!four_reg)
        begin
            abs_next[LANES-1] = '0;
        end
    end

    // saturate at 64 bits for the widest inputs
    always_comb
    begin
        sum_full = 65'(sq1_reg[0]) + 65'(sq1_reg[1]) + 65'(sq1_reg[2]) + 65'(sq1_reg[3]);
        sum_sat  = sum_full[64] ? '1 : sum_full[63:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            abs0_reg <= abs_next;
            neg0_reg <= neg_next;
            for (int i = 0; i < LANES; i++)
            begin
                sq1_reg[i] <= abs0_reg[i] * abs0_reg[i];
            end
            abs1_reg <= abs0_reg;
            neg1_reg <= neg0_reg;
            val2_reg <= RW'(sum_sat);
            abs2_reg <= abs1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    assign sv[0]    = v2_reg;
    assign sval[0]  = val2_reg;
    assign srem[0]  = '0;
    assign sroot[0] = '0;
    assign sabs[0]  = abs2_reg;
    assign sneg[0]  = neg2_reg;

    for (genvar k = 0; k < MW; k++)
    begin : g_sqrt
        vn_sqrt_cell #(.W(W)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (sv[k]),
            .val_in    (sval[k]),
            .rem_in    (srem[k]),
            .root_in   (sroot[k]),
            .abs_in    (sabs[k]),
            .neg_in    (sneg[k]),
            .valid_out (sv[k+1]),
            .val_out   (sval[k+1]),
            .rem_out   (srem[k+1]),
            .root_out  (sroot[k+1]),
            .abs_out   (sabs[k+1]),
            .neg_out   (sneg[k+1])
        );
    end

    always_comb
    begin
        small_next = (64'(thr_reg) > 64'(sroot[MW])) || (sroot[MW] == '0);
        for (int i = 0; i < LANES; i++)
        begin
            remt_next[i] = (MW+1)'(sabs[MW][i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vt_reg <= 1'b0;
        end
        else if (en)
        begin
            vt_reg <= sv[MW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            smallt_reg <= small_next;
            magnt_reg  <= sroot[MW];
            remt_reg   <= remt_next;
            negt_reg   <= sneg[MW];
        end
    end

    assign dv[0]     = vt_reg;
    assign dsmall[0] = smallt_reg;
    assign dmagn[0]  = magnt_reg;
    assign drem[0]   = remt_reg;
    assign dq[0]     = '0;
    assign dneg[0]   = negt_reg;

    for (genvar k = 0; k < QW; k++)
    begin : g_div
        vn_div_cell #(.W(W), .QW(QW)) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv[k]),
            .small_in  (dsmall[k]),
            .magn_in   (dmagn[k]),
            .rem_in    (drem[k]),
            .q_in      (dq[k]),
            .neg_in    (dneg[k]),
            .valid_out (dv[k+1]),
            .small_out (dsmall[k+1]),
            .magn_out  (dmagn[k+1]),
            .rem_out   (drem[k+1]),
            .q_out     (dq[k+1]),
            .neg_out   (dneg[k+1])
        );
    end

    always_comb
    begin
        qv = '0;
        rv = '0;
        for (int i = 0; i < LANES; i++)
        begin
            qv          = 64'(dq[QW][i]);
            rv          = dneg[QW][i] ? (64'd0 - qv) : qv;
            res_next[i] = dsmall[QW] ? '0 : rv[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= dv[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg       <= res_next;
            small_out_reg <= dsmall[QW];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = res_reg[0];
    assign out_y     = res_reg[1];
    assign out_z     = res_reg[2];
    assign out_w     = res_reg[3];
    assign too_small = small_out_reg;

`ifndef SYNTHESIS
    a_small_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && too_small |-> (out_x == '0 && out_y == '0 && out_z == '0 && out_w == '0))
        else $error("flagged beat carries a nonzero component");

    a_three_w_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !four_reg |-> out_w == '0)
        else $error("w nonzero in three-component mode");

    a_zero_magn_small: assert property (@(posedge clk) disable iff (!rst_n)
        vt_reg && magnt_reg == '0 |-> smallt_reg)
        else $error("zero magnitude not flagged");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_reg))
        else $error("stalled result changed");
`endif

endmodule

FILE: rtl/vn_sqrt_cell.sv
module vn_sqrt_cell #(
    parameter int W = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         valid_in,
    input  logic [2*(W+1)-1:0]           val_in,
    input  logic [W+2:0]                 rem_in,
    input  logic [W:0]                   root_in,
    input  logic [vn_pkg::LANES-1:0][W-1:0] abs_in,
    input  logic [vn_pkg::LANES-1:0]     neg_in,
    output logic                         valid_out,
    output logic [2*(W+1)-1:0]           val_out,
    output logic [W+2:0]                 rem_out,
    output logic [W:0]                   root_out,
    output logic [vn_pkg::LANES-1:0][W-1:0] abs_out,
    output logic [vn_pkg::LANES-1:0]     neg_out
);
    import vn_pkg::*;

    localparam int MW = W + 1;
    localparam int RW = 2 * MW;

    logic                      valid_reg;
    logic [RW-1:0]             val_reg, val_next;
    logic [MW+1:0]             rem_reg, rem_next;
    logic [MW-1:0]             root_reg, root_next;
    logic [LANES-1:0][W-1:0]   abs_reg;
    logic [LANES-1:0]          neg_reg;
    logic [MW+1:0]             rem_s;
    logic [MW+1:0]             trial;
    logic                      ge;

    // one root bit per cell
    always_comb
    begin
        rem_s     = {rem_in[MW-1:0], val_in[RW-1:RW-2]};
        trial     = {root_in, 2'b01};
        ge        = (rem_s >= trial);
        rem_next  = ge ? (rem_s - trial) : rem_s;
        root_next = {root_in[MW-2:0], ge};
        val_next  = {val_in[RW-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg  <= val_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            abs_reg  <= abs_in;
            neg_reg  <= neg_in;
        end
    end

    assign valid_out = valid_reg;
    assign val_out   = val_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign abs_out   = abs_reg;
    assign neg_out   = neg_reg;

endmodule

FILE: rtl/vn_div_cell.sv
module vn_div_cell #(
    parameter int W  = 16,
    parameter int QW = 15
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            valid_in,
    input  logic                            small_in,
    input  logic [W:0]                      magn_in,
    input  logic [vn_pkg::LANES-1:0][W+1:0] rem_in,
    input  logic [vn_pkg::LANES-1:0][QW-1:0] q_in,
    input  logic [vn_pkg::LANES-1:0]        neg_in,
    output logic                            valid_out,
    output logic                            small_out,
    output logic [W:0]                      magn_out,
    output logic [vn_pkg::LANES-1:0][W+1:0] rem_out,
    output logic [vn_pkg::LANES-1:0][QW-1:0] q_out,
    output logic [vn_pkg::LANES-1:0]        neg_out
);
    import vn_pkg::*;

    localparam int MW = W + 1;

    logic                      valid_reg;
    logic                      small_reg;
    logic [MW-1:0]             magn_reg;
    logic [LANES-1:0][MW:0]    rem_reg, rem_next;
    logic [LANES-1:0][QW-1:0]  q_reg, q_next;
    logic [LANES-1:0]          neg_reg;
    logic [MW:0]               diff;
    logic                      ge;

    // one quotient bit per cell in every lane
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            ge          = (rem_in[i] >= {1'b0, magn_in});
            diff        = ge ? (rem_in[i] - {1'b0, magn_in}) : rem_in[i];
            rem_next[i] = {diff[MW-1:0], 1'b0};
            q_next[i]   = {q_in[i][QW-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            small_reg <= small_in;
            magn_reg  <= magn_in;
            rem_reg   <= rem_next;
            q_reg     <= q_next;
            neg_reg   <= neg_in;
        end
    end

    assign valid_out = valid_reg;
    assign small_out = small_reg;
    assign magn_out  = magn_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign neg_out   = neg_reg;

endmodule
